// ===== src/trapezoid_column_line_mapper_macros.svh =====
// Assertion macros shared by the column line mapper RTL.
// Each macro expects signals named clk and rst_n in the using scope.
`ifndef TRAPEZOID_COLUMN_LINE_MAPPER_MACROS_SVH
`define TRAPEZOID_COLUMN_LINE_MAPPER_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define TCLM_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define TCLM_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/tclm_pkg.sv =====
// Package for the trapezoid column line mapper: widths, register codes,
// sequencer states and the request and response structs of the units. No dependencies.
`default_nettype none

package tclm_pkg;

    localparam int MAX_LINES   = 1024;
    localparam int MAX_COLUMNS = 2048;
    localparam int FRAC_BITS   = 16;

    localparam int LINE_W     = $clog2(MAX_LINES) + 1;   // line counters and heights
    localparam int OUT_LINE_W = 10;
    localparam int COL_W      = 11;
    localparam int WIDTH_W    = 12;
    localparam int HC_W       = 20;
    localparam int BPP_W      = 4;
    localparam int STRIDE_W   = 15;
    localparam int ADDR_W     = 24;
    localparam int ACC_W      = 32;
    localparam int CFG_W      = 20;
    localparam int CFG_IDX_W  = 3;
    localparam int GUARD_W    = $clog2(MAX_LINES) + 1;

    localparam int MAC_A_W = 12;
    localparam int MAC_B_W = 20;
    localparam int MAC_C_W = 15;
    localparam int MAC_W   = 32;
    localparam int PROD_W  = MAC_W - FRAC_BITS;

    localparam int DIV_N_W   = LINE_W + FRAC_BITS;
    localparam int DIV_CNT_W = $clog2(DIV_N_W + 1);

    localparam logic [ACC_W-1:0] ONE_Q = ACC_W'(64'd1 << FRAC_BITS);
    localparam logic [ACC_W-1:0] TWO_Q = ACC_W'(64'd2 << FRAC_BITS);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DST_HEIGHT     = 3'd0,
        CFG_DST_WIDTH      = 3'd1,
        CFG_SRC_HEIGHT     = 3'd2,
        CFG_HEIGHT_CHANGE  = 3'd3,
        CFG_NARROWING_LEFT = 3'd4,
        CFG_BYTES_PER_PIX  = 3'd5,
        CFG_SRC_STRIDE     = 3'd6,
        CFG_DST_STRIDE     = 3'd7
    } cfg_index_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_START_MUL,
        S_START_HGT,
        S_DIV,
        S_SKIP,
        S_SOFF,
        S_SADDR,
        S_DOFF,
        S_DADDR,
        S_EMIT
    } state_t;

    typedef struct packed {
        logic               en;
        logic [MAC_A_W-1:0] a;
        logic [MAC_B_W-1:0] b;
        logic [MAC_C_W-1:0] c;
    } mac_req_t;

    typedef struct packed {
        logic               start;
        logic [DIV_N_W-1:0] numer;
        logic [LINE_W-1:0]  denom;
    } div_req_t;

    typedef struct packed {
        logic               done;
        logic [DIV_N_W-1:0] quot;
    } div_resp_t;

endpackage

`default_nettype wire

// ===== src/trapezoid_column_line_mapper.sv =====
// Trapezoid column line mapper top level: sequencer, column state, config.
// Depends on tclm_pkg, tclm_mac, tclm_div and the assertion macro header.
//
// Usage:
//  Config: cfg_we writes cfg_data into register cfg_index.
//   Write only while no request is in flight.
//  Input: in_valid/in_ready. A request with start_column set loads a new
//   column; its height is formed with the shared multiply-add unit and its
//   step ratio with the bit-serial divider (one bit per cycle). A start
//   request yields no result; a request with start_column clear advances
//   one output line.
//  Output: out_valid/out_ready, one result per advance while the column is
//   open. An advance steps S_SOFF, S_SADDR, S_DOFF, S_DADDR, S_EMIT; in
//   shrink mode S_SKIP comes first and drops source lines (at most 1024
//   skips). Four passes through the multiply-add unit build the two byte
//   addresses. Advances with no open column are taken and dropped.
//  A stalled receiver holds the output register; the next request is still
//   taken, and its result waits in the sequencer until the register frees.
//  Reset: the config and control registers take their reset values, no
//   column is open, and the block is ready at once; data registers are not reset.
`default_nettype none
`include "trapezoid_column_line_mapper_macros.svh"

module trapezoid_column_line_mapper
    import tclm_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_W-1:0]      cfg_data,
    input  wire logic                  in_valid,
    output logic                       in_ready,
    input  wire logic                  start_column,
    input  wire logic [COL_W-1:0]      target_column,
    input  wire logic [COL_W-1:0]      source_column,
    output logic                       out_valid,
    input  wire logic                  out_ready,
    output logic [OUT_LINE_W-1:0]      src_line,
    output logic [OUT_LINE_W-1:0]      dst_line,
    output logic [ADDR_W-1:0]          src_address,
    output logic [ADDR_W-1:0]          dst_address,
    output logic                       last_line
);

    // configuration
    logic [LINE_W-1:0]   dst_height_reg;
    logic [WIDTH_W-1:0]  dst_width_reg;
    logic [LINE_W-1:0]   src_height_reg;
    logic [HC_W-1:0]     height_change_reg;
    logic                narrowing_left_reg;
    logic [BPP_W-1:0]    bpp_reg;
    logic [STRIDE_W-1:0] src_stride_reg;
    logic [STRIDE_W-1:0] dst_stride_reg;

    // sequencer and column state
    state_t              state_reg,        state_next;
    logic                column_active_reg, column_active_next;
    logic                shrink_mode_reg,  shrink_mode_next;
    logic [COL_W-1:0]    held_tgt_reg,     held_tgt_next;
    logic [COL_W-1:0]    held_src_reg,     held_src_next;
    logic [LINE_W-1:0]   column_height_reg, column_height_next;
    logic [OUT_LINE_W-1:0] top_offset_reg, top_offset_next;
    logic [LINE_W-1:0]   out_count_reg,    out_count_next;
    logic [LINE_W-1:0]   src_count_reg,    src_count_next;
    logic [ACC_W-1:0]    ratio_step_reg,   ratio_step_next;
    logic [ACC_W-1:0]    ratio_acc_reg,    ratio_acc_next;
    logic [GUARD_W-1:0]  guard_reg,        guard_next;
    logic [ADDR_W-1:0]   src_addr_reg,     src_addr_next;

    // output register
    logic                  out_valid_reg,  out_valid_next;
    logic [OUT_LINE_W-1:0] src_line_reg,   src_line_next;
    logic [OUT_LINE_W-1:0] dst_line_reg,   dst_line_next;
    logic [ADDR_W-1:0]     src_address_reg, src_address_next;
    logic [ADDR_W-1:0]     dst_address_reg, dst_address_next;
    logic                  last_line_reg,  last_line_next;

    mac_req_t          mac_req;
    logic [MAC_W-1:0]  mac_q;
    div_req_t          div_req;
    div_resp_t         div_resp;

    logic                in_fire;
    logic                emit_fire;
    logic [WIDTH_W-1:0]  col_dist;
    logic [PROD_W-1:0]   prod;
    logic                prod_ge;
    logic [LINE_W-1:0]   height_new;
    logic [LINE_W-1:0]   height_diff;
    logic                shrink_new;
    logic [LINE_W-1:0]   src_count_inc;
    logic                skip_match;
    logic [LINE_W:0]     dline;
    logic                last_now;
    logic [LINE_W-1:0]   out_count_inc;

    tclm_mac u_mac (
        .clk    (clk),
        .req    (mac_req),
        .result (mac_q)
    );

    tclm_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .resp  (div_resp)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dst_height_reg     <= LINE_W'(1024);
            dst_width_reg      <= WIDTH_W'(2048);
            src_height_reg     <= LINE_W'(1024);
            height_change_reg  <= '0;
            narrowing_left_reg <= 1'b1;
            bpp_reg            <= BPP_W'(4);
            src_stride_reg     <= STRIDE_W'(8192);
            dst_stride_reg     <= STRIDE_W'(8192);
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_DST_HEIGHT:     dst_height_reg     <= cfg_data[LINE_W-1:0];
                CFG_DST_WIDTH:      dst_width_reg      <= cfg_data[WIDTH_W-1:0];
                CFG_SRC_HEIGHT:     src_height_reg     <= cfg_data[LINE_W-1:0];
                CFG_HEIGHT_CHANGE:  height_change_reg  <= cfg_data[HC_W-1:0];
                CFG_NARROWING_LEFT: narrowing_left_reg <= cfg_data[0];
                CFG_BYTES_PER_PIX:  bpp_reg            <= cfg_data[BPP_W-1:0];
                CFG_SRC_STRIDE:     src_stride_reg     <= cfg_data[STRIDE_W-1:0];
                CFG_DST_STRIDE:     dst_stride_reg     <= cfg_data[STRIDE_W-1:0];
                default:            ;
            endcase
        end
    end

    always_comb
    begin
        in_ready  = (state_reg == S_IDLE);
        in_fire   = in_valid && in_ready;
        emit_fire = (state_reg == S_EMIT) && (!out_valid_reg || out_ready);

        if (narrowing_left_reg)
            col_dist = {1'b0, held_tgt_reg};
        else if (dst_width_reg > {1'b0, held_tgt_reg})
            col_dist = dst_width_reg - {1'b0, held_tgt_reg};
        else
            col_dist = '0;

        prod        = mac_q[MAC_W-1:FRAC_BITS];
        prod_ge     = prod >= PROD_W'(dst_height_reg);
        height_new  = prod_ge ? '0 : LINE_W'(dst_height_reg - prod[LINE_W-1:0]);
        height_diff = prod_ge ? dst_height_reg : prod[LINE_W-1:0];
        shrink_new  = height_new < src_height_reg;

        src_count_inc = src_count_reg + 1'b1;
        out_count_inc = out_count_reg + 1'b1;
        skip_match    = ACC_W'({src_count_inc, FRAC_BITS'(0)}) ==
                        {ratio_acc_reg[ACC_W-1:FRAC_BITS], FRAC_BITS'(0)};
        dline         = {1'b0, out_count_reg} + (LINE_W+1)'(top_offset_reg);
        last_now      = ({1'b0, out_count_reg} + 1'b1) >= {1'b0, column_height_reg};

        state_next         = state_reg;
        column_active_next = column_active_reg;
        shrink_mode_next   = shrink_mode_reg;
        held_tgt_next      = held_tgt_reg;
        held_src_next      = held_src_reg;
        column_height_next = column_height_reg;
        top_offset_next    = top_offset_reg;
        out_count_next     = out_count_reg;
        src_count_next     = src_count_reg;
        ratio_step_next    = ratio_step_reg;
        ratio_acc_next     = ratio_acc_reg;
        guard_next         = guard_reg;
        src_addr_next      = src_addr_reg;

        mac_req  = '0;
        div_req  = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    if (start_column)
                    begin
                        if ({1'b0, target_column} < (COL_W+1)'(MAX_COLUMNS) &&
                            {1'b0, source_column} < (COL_W+1)'(MAX_COLUMNS))
                        begin
                            held_tgt_next = target_column;
                            held_src_next = source_column;
                            state_next    = S_START_MUL;
                        end
                    end
                    else if (column_active_reg)
                    begin
                        guard_next = '0;
                        state_next = shrink_mode_reg ? S_SKIP : S_SOFF;
                    end
                end
            end
            S_START_MUL:
            begin
                mac_req.en = 1'b1;
                mac_req.a  = MAC_A_W'(col_dist);
                mac_req.b  = MAC_B_W'(height_change_reg);
                state_next = S_START_HGT;
            end
            S_START_HGT:
            begin
                column_height_next = height_new;
                top_offset_next    = height_diff[LINE_W-1:1];
                shrink_mode_next   = shrink_new;
                out_count_next     = '0;
                src_count_next     = '0;
                column_active_next = (height_new != '0);
                if (!shrink_new && src_height_reg == '0)
                begin
                    // no source lines: the step saturates and the line never moves
                    ratio_step_next = '1;
                    ratio_acc_next  = '1;
                    state_next      = S_IDLE;
                end
                else
                begin
                    div_req.start = 1'b1;
                    div_req.numer = shrink_new ? {src_height_reg, FRAC_BITS'(0)}
                                               : {height_new, FRAC_BITS'(0)};
                    div_req.denom = shrink_new ? LINE_W'(src_height_reg - height_new)
                                               : src_height_reg;
                    state_next    = S_DIV;
                end
            end
            S_DIV:
            begin
                if (div_resp.done)
                begin
                    ratio_step_next = ACC_W'(div_resp.quot);
                    ratio_acc_next  = ACC_W'(div_resp.quot);
                    state_next      = S_IDLE;
                end
            end
            S_SKIP:
            begin
                // drop source lines while the running ratio lands on the next one
                if (skip_match && guard_reg != GUARD_W'(MAX_LINES))
                begin
                    ratio_acc_next = ratio_acc_reg + ratio_step_reg;
                    src_count_next = src_count_inc;
                    guard_next     = guard_reg + 1'b1;
                end
                else
                begin
                    state_next = S_SOFF;
                end
            end
            S_SOFF:
            begin
                mac_req.en = 1'b1;
                mac_req.a  = MAC_A_W'(held_src_reg);
                mac_req.b  = MAC_B_W'(bpp_reg);
                state_next = S_SADDR;
            end
            S_SADDR:
            begin
                mac_req.en = 1'b1;
                mac_req.a  = MAC_A_W'(src_count_reg);
                mac_req.b  = MAC_B_W'(src_stride_reg);
                mac_req.c  = mac_q[MAC_C_W-1:0];
                state_next = S_DOFF;
            end
            S_DOFF:
            begin
                src_addr_next = mac_q[ADDR_W-1:0];
                mac_req.en    = 1'b1;
                mac_req.a     = MAC_A_W'(held_tgt_reg);
                mac_req.b     = MAC_B_W'(bpp_reg);
                state_next    = S_DADDR;
            end
            S_DADDR:
            begin
                mac_req.en = 1'b1;
                mac_req.a  = MAC_A_W'(dline);
                mac_req.b  = MAC_B_W'(dst_stride_reg);
                mac_req.c  = mac_q[MAC_C_W-1:0];
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (emit_fire)
                begin
                    if (shrink_mode_reg)
                    begin
                        src_count_next = src_count_inc;
                    end
                    else if (ratio_acc_reg < TWO_Q)
                    begin
                        ratio_acc_next = ratio_acc_reg + ratio_step_reg - ONE_Q;
                        src_count_next = src_count_inc;
                    end
                    else
                    begin
                        ratio_acc_next = ratio_acc_reg - ONE_Q;
                    end
                    out_count_next = out_count_inc;
                    if (out_count_inc >= column_height_reg)
                        column_active_next = 1'b0;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        out_valid_next   = out_valid_reg;
        src_line_next    = src_line_reg;
        dst_line_next    = dst_line_reg;
        src_address_next = src_address_reg;
        dst_address_next = dst_address_reg;
        last_line_next   = last_line_reg;
        if (emit_fire)
        begin
            out_valid_next   = 1'b1;
            src_line_next    = src_count_reg[OUT_LINE_W-1:0];
            dst_line_next    = dline[OUT_LINE_W-1:0];
            src_address_next = src_addr_reg;
            dst_address_next = mac_q[ADDR_W-1:0];
            last_line_next   = last_now;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= S_IDLE;
            column_active_reg <= 1'b0;
            shrink_mode_reg   <= 1'b0;
            held_tgt_reg      <= '0;
            held_src_reg      <= '0;
            column_height_reg <= '0;
            top_offset_reg    <= '0;
            out_count_reg     <= '0;
            src_count_reg     <= '0;
            ratio_step_reg    <= '0;
            ratio_acc_reg     <= '0;
            guard_reg         <= '0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            state_reg         <= state_next;
            column_active_reg <= column_active_next;
            shrink_mode_reg   <= shrink_mode_next;
            held_tgt_reg      <= held_tgt_next;
            held_src_reg      <= held_src_next;
            column_height_reg <= column_height_next;
            top_offset_reg    <= top_offset_next;
            out_count_reg     <= out_count_next;
            src_count_reg     <= src_count_next;
            ratio_step_reg    <= ratio_step_next;
            ratio_acc_reg     <= ratio_acc_next;
            guard_reg         <= guard_next;
            out_valid_reg     <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        src_addr_reg    <= src_addr_next;
        src_line_reg    <= src_line_next;
        dst_line_reg    <= dst_line_next;
        src_address_reg <= src_address_next;
        dst_address_reg <= dst_address_next;
        last_line_reg   <= last_line_next;
    end

    assign out_valid   = out_valid_reg;
    assign src_line    = src_line_reg;
    assign dst_line    = dst_line_reg;
    assign src_address = src_address_reg;
    assign dst_address = dst_address_reg;
    assign last_line   = last_line_reg;

    `TCLM_ASSERT_NOW(a_emit_open, emit_fire, column_active_reg, "result from a closed column")
    `TCLM_ASSERT_NOW(a_div_done_wait, div_resp.done, state_reg == S_DIV, "stray divider result")
    `TCLM_ASSERT_NOW(a_count_bound, column_active_reg, out_count_reg < column_height_reg, "line count past column height")
    `TCLM_ASSERT_NEXT(a_last_closes, emit_fire && last_now, !column_active_reg, "column open after last line")

endmodule

`default_nettype wire

// ===== src/tclm_mac.sv =====
// Shared multiply-add unit: result = a * b + c, registered, loaded on request.
// Depends on tclm_pkg.
`default_nettype none

module tclm_mac
    import tclm_pkg::*;
(
    input  wire logic             clk,
    input  wire mac_req_t         req,
    output logic [MAC_W-1:0]      result
);

    logic [MAC_W-1:0] result_reg;
    logic [MAC_W-1:0] result_next;

    always_comb
    begin
        result_next = MAC_W'(MAC_W'(req.a) * MAC_W'(req.b) + MAC_W'(req.c));
    end

    always_ff @(posedge clk)
    begin
        if (req.en)
        begin
            result_reg <= result_next;
        end
    end

    assign result = result_reg;

endmodule

`default_nettype wire

// ===== src/tclm_div.sv =====
// Restoring divider, one quotient bit per cycle, for the column step ratio.
// Depends on tclm_pkg.
`default_nettype none

module tclm_div
    import tclm_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire div_req_t req,
    output div_resp_t     resp
);

    logic [LINE_W-1:0]    rem_reg,   rem_next;
    logic [DIV_N_W-1:0]   quo_reg,   quo_next;
    logic [LINE_W-1:0]    den_reg,   den_next;
    logic [DIV_CNT_W-1:0] cnt_reg,   cnt_next;
    logic                 done_reg,  done_next;

    logic [LINE_W:0] shifted;
    logic            ge;

    always_comb
    begin
        shifted   = {rem_reg, quo_reg[DIV_N_W-1]};
        ge        = shifted >= {1'b0, den_reg};
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        den_next  = den_reg;
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        if (req.start)
        begin
            rem_next = '0;
            quo_next = req.numer;
            den_next = req.denom;
            cnt_next = DIV_CNT_W'(DIV_N_W);
        end
        else if (cnt_reg != '0)
        begin
            // remainder stays below the divisor, so the top bit drops
            rem_next = ge ? LINE_W'(shifted - {1'b0, den_reg}) : shifted[LINE_W-1:0];
            quo_next = {quo_reg[DIV_N_W-2:0], ge};
            cnt_next = cnt_reg - 1'b1;
            done_next = (cnt_reg == DIV_CNT_W'(1));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        den_reg <= den_next;
    end

    assign resp.done = done_reg;
    assign resp.quot = quo_reg;

endmodule

`default_nettype wire
